@@ src/cfa_pkg.sv @@
// cfa_pkg: codes, field widths, reset values and month-length helpers for the
// calendar field adjuster.
// Depends on nothing; used by calendar_field_adjuster and cfa_checker.
package cfa_pkg;

   typedef logic [1:0] action_type;
   typedef logic [2:0] field_type;
   typedef logic [6:0] year_type;
   typedef logic [3:0] month_type;
   typedef logic [4:0] day_type;
   typedef logic [4:0] hour_type;
   typedef logic [5:0] minute_type;
   typedef logic [5:0] second_type;

   // action codes
   localparam action_type ACT_UP   = 2'd0;
   localparam action_type ACT_DOWN = 2'd1;
   localparam action_type ACT_READ = 2'd2;

   // field codes
   localparam field_type FLD_YEAR   = 3'd0;
   localparam field_type FLD_MONTH  = 3'd1;
   localparam field_type FLD_DAY    = 3'd2;
   localparam field_type FLD_HOUR   = 3'd3;
   localparam field_type FLD_MINUTE = 3'd4;
   localparam field_type FLD_SECOND = 3'd5;

   // field limits
   localparam year_type   YEAR_MAX   = 7'd99;
   localparam month_type  MONTH_MAX  = 4'd12;
   localparam month_type  MONTH_FEB  = 4'd2;
   localparam day_type    DAY_MAX    = 5'd31;
   localparam hour_type   HOUR_MAX   = 5'd23;
   localparam minute_type MINUTE_MAX = 6'd59;
   localparam second_type SECOND_MAX = 6'd59;

   // reset values
   localparam year_type   YEAR_RST   = 7'd21;
   localparam month_type  MONTH_RST  = 4'd3;
   localparam day_type    DAY_RST    = 5'd10;
   localparam hour_type   HOUR_RST   = 5'd17;
   localparam minute_type MINUTE_RST = 6'd41;
   localparam second_type SECOND_RST = 6'd35;

   // Days in a month; every fourth year (year 0 included) is a leap year.
   function automatic day_type month_len(month_type month, year_type year);
      day_type len;
      len = 5'd31;
      if (month == MONTH_FEB) begin
         len = (year[1:0] == 2'd0) ? 5'd29 : 5'd28;
      end else begin
         case (month) inside
            4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
            default:                 len = 5'd31;
         endcase
      end
      return len;
   endfunction

   function automatic year_type year_inc(year_type year);
      return (year >= YEAR_MAX) ? 7'd0 : year + 7'd1;
   endfunction

   function automatic year_type year_dec(year_type year);
      return (year == 7'd0) ? YEAR_MAX : year - 7'd1;
   endfunction

endpackage

@@ src/calendar_field_adjuster.sv @@
// calendar_field_adjuster: two-digit-year calendar and 24-hour clock whose
// fields are stepped up or down by one per request word.
// Depends on cfa_pkg.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+------------------------------------
//   req     | in        | req_valid/req_stall| req_action, req_field_select
//   rsp     | out       | rsp_valid/rsp_stall| rsp_year_out .. rsp_second_out
//
// One request word is taken per clock unless req_stall is raised; its response
// word is valid on the next cycle. The calendar registers double as the
// response register, so a new word is taken whenever the response slot is
// empty or is being drained in the same cycle.
// Reset (synchronous) loads 21-03-10 17:41:35 and empties the response slot.
// While rsp_stall holds a valid response, req_stall is raised and the
// calendar holds.
module calendar_field_adjuster
   import cfa_pkg::*;
(
   input  logic       clock,
   input  logic       reset,

   input  logic       req_valid,
   output logic       req_stall,
   input  action_type req_action,
   input  field_type  req_field_select,

   output logic       rsp_valid,
   input  logic       rsp_stall,
   output year_type   rsp_year_out,
   output month_type  rsp_month_out,
   output day_type    rsp_day_out,
   output hour_type   rsp_hour_out,
   output minute_type rsp_minute_out,
   output second_type rsp_second_out
);

   // calendar state, also the response payload
   year_type   year_ff,   year_in;
   month_type  month_ff,  month_in;
   day_type    day_ff;
   hour_type   hour_ff,   hour_in;
   minute_type minute_ff, minute_in;
   second_type second_ff, second_in;
   logic       rsp_valid_ff, rsp_valid_in;

   // day gets one spare bit so that day 31 + 1 can be seen before the fixup
   logic [5:0] day_in;
   logic [5:0] day_step;
   month_type  month_step;
   year_type   year_step;
   day_type    len_step;
   logic       need_fix;
   logic       is_up;
   logic       is_step;
   logic       accept;

   // Stall only while a finished word sits unclaimed in the response slot.
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;

   assign is_up   = (req_action == ACT_UP);
   assign is_step = (req_action == ACT_UP) || (req_action == ACT_DOWN);

   // First pass: step the chosen field, with month carry and borrow.
   always_comb begin
      year_step  = year_ff;
      month_step = month_ff;
      day_step   = {1'b0, day_ff};
      hour_in    = hour_ff;
      minute_in  = minute_ff;
      second_in  = second_ff;
      need_fix   = 1'b0;
      if (is_step) begin
         case (req_field_select)
            FLD_YEAR: begin
               year_step = is_up ? year_inc(year_ff) : year_dec(year_ff);
               need_fix  = 1'b1;
            end
            FLD_MONTH: begin
               if (is_up) begin
                  if (month_ff >= MONTH_MAX) begin
                     month_step = 4'd1;
                     year_step  = year_inc(year_ff);
                  end else begin
                     month_step = month_ff + 4'd1;
                  end
               end else begin
                  if (month_ff <= 4'd1) begin
                     month_step = MONTH_MAX;
                     year_step  = year_dec(year_ff);
                  end else begin
                     month_step = month_ff - 4'd1;
                  end
               end
               need_fix = 1'b1;
            end
            FLD_DAY: begin
               if (is_up) begin
                  day_step = {1'b0, day_ff} + 6'd1;
                  need_fix = 1'b1;
               end else if (day_ff <= 5'd1) begin
                  // borrow from the month, land on its last day
                  if (month_ff <= 4'd1) begin
                     month_step = MONTH_MAX;
                     year_step  = year_dec(year_ff);
                  end else begin
                     month_step = month_ff - 4'd1;
                  end
                  day_step = {1'b0, month_len(month_step, year_step)};
               end else begin
                  day_step = {1'b0, day_ff} - 6'd1;
               end
            end
            FLD_HOUR: begin
               if (is_up) hour_in = (hour_ff >= HOUR_MAX) ? 5'd0 : hour_ff + 5'd1;
               else       hour_in = (hour_ff == 5'd0) ? HOUR_MAX : hour_ff - 5'd1;
            end
            FLD_MINUTE: begin
               if (is_up) minute_in = (minute_ff >= MINUTE_MAX) ? 6'd0 : minute_ff + 6'd1;
               else       minute_in = (minute_ff == 6'd0) ? MINUTE_MAX : minute_ff - 6'd1;
            end
            FLD_SECOND: begin
               if (is_up) second_in = (second_ff >= SECOND_MAX) ? 6'd0 : second_ff + 6'd1;
               else       second_in = (second_ff == 6'd0) ? SECOND_MAX : second_ff - 6'd1;
            end
            default: begin
               // unused field codes leave everything as it stands
            end
         endcase
      end
   end

   // Second pass: a day past the month's end rolls to day 1 of the next month.
   assign len_step = month_len(month_step, year_step);

   always_comb begin
      year_in  = year_step;
      month_in = month_step;
      day_in   = day_step;
      if (need_fix && (day_step > {1'b0, len_step})) begin
         day_in = 6'd1;
         if (month_step >= MONTH_MAX) begin
            month_in = 4'd1;
            year_in  = year_inc(year_step);
         end else begin
            month_in = month_step + 4'd1;
         end
      end
   end

   // Response slot fills on accept, drains when the consumer takes it.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (~rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         year_ff      <= YEAR_RST;
         month_ff     <= MONTH_RST;
         day_ff       <= DAY_RST;
         hour_ff      <= HOUR_RST;
         minute_ff    <= MINUTE_RST;
         second_ff    <= SECOND_RST;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         // advance the calendar only on an accepted word
         if (accept) begin
            year_ff   <= year_in;
            month_ff  <= month_in;
            day_ff    <= day_in[4:0];
            hour_ff   <= hour_in;
            minute_ff <= minute_in;
            second_ff <= second_in;
         end
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_year_out   = year_ff;
   assign rsp_month_out  = month_ff;
   assign rsp_day_out    = day_ff;
   assign rsp_hour_out   = hour_ff;
   assign rsp_minute_out = minute_ff;
   assign rsp_second_out = second_ff;

endmodule

@@ src/cfa_checker.sv @@
// cfa_checker: port-level assertions for calendar_field_adjuster, and the
// bind that attaches them. Depends on cfa_pkg.
module cfa_checker
   import cfa_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input action_type req_action,
   input field_type  req_field_select,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input year_type   rsp_year_out,
   input month_type  rsp_month_out,
   input day_type    rsp_day_out,
   input hour_type   rsp_hour_out,
   input minute_type rsp_minute_out,
   input second_type rsp_second_out
);

   // a stalled response word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_year_out) &&
      $stable(rsp_month_out) && $stable(rsp_day_out) && $stable(rsp_hour_out) &&
      $stable(rsp_minute_out) && $stable(rsp_second_out))
      else $error("response word changed while stalled");

   // every accepted request word yields a response word next cycle
   a_req_to_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> rsp_valid)
      else $error("accepted request produced no response");

   // backpressure only when the response slot is full
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled without a blocked response");

   // every field stays in its calendar range
   a_ranges: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_year_out <= YEAR_MAX && rsp_month_out >= 4'd1 &&
      rsp_month_out <= MONTH_MAX && rsp_day_out >= 5'd1 &&
      rsp_day_out <= month_len(rsp_month_out, rsp_year_out) &&
      rsp_hour_out <= HOUR_MAX && rsp_minute_out <= MINUTE_MAX &&
      rsp_second_out <= SECOND_MAX)
      else $error("calendar field out of range");

endmodule

bind calendar_field_adjuster cfa_checker u_cfa_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .req_action       (req_action),
   .req_field_select (req_field_select),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_year_out     (rsp_year_out),
   .rsp_month_out    (rsp_month_out),
   .rsp_day_out      (rsp_day_out),
   .rsp_hour_out     (rsp_hour_out),
   .rsp_minute_out   (rsp_minute_out),
   .rsp_second_out   (rsp_second_out)
);

@@ tb/sv/tb_top.sv @@
// tb_top: self-checking bench for calendar_field_adjuster; a directed table, then random
// step runs, checked word by word against an in-bench calendar model.
// Depends on cfa_pkg and calendar_field_adjuster.
module tb_top
   import cfa_pkg::*;
();

   // codes the package leaves unnamed: a spare action and the two unused field selects
   localparam action_type ACT_SPARE  = 2'd3;
   localparam field_type  FLD_SPARE6 = 3'd6;
   localparam field_type  FLD_SPARE7 = 3'd7;

   localparam int STEP_TARGET = 280;     // up/down steps on real fields in the random part
   localparam int LONG_HOLD   = 64;      // cycles of the one long response hold-off
   localparam int DRAIN_TAIL  = 4;       // extra cycles after the last drain; leave a little margin
   localparam int CYCLE_LIMIT = 200000;

   typedef struct packed {
      year_type   year;
      month_type  month;
      day_type    day;
      hour_type   hour;
      minute_type minute;
      second_type second;
   } cal_word_type;

   typedef struct {
      action_type   act;
      field_type    fld;
      int           reps;
      cal_word_type after;   // calendar as it stands after the last repeat
   } step_row_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   action_type req_action = ACT_READ;
   field_type  req_field_select = FLD_YEAR;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   year_type   rsp_year_out;
   month_type  rsp_month_out;
   day_type    rsp_day_out;
   hour_type   rsp_hour_out;
   minute_type rsp_minute_out;
   second_type rsp_second_out;

   cal_word_type cal_now;              // model of the block's calendar registers
   cal_word_type expected_words[$];    // one entry per accepted request word
   step_row_type script[$];
   int           failures = 0;
   int           cycle_count = 0;
   int           burst_left = 0;
   bit           long_hold_req = 1'b0;
   bit           long_hold_done = 1'b0;

   calendar_field_adjuster u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_action       (req_action),
      .req_field_select (req_field_select),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_year_out     (rsp_year_out),
      .rsp_month_out    (rsp_month_out),
      .rsp_day_out      (rsp_day_out),
      .rsp_hour_out     (rsp_hour_out),
      .rsp_minute_out   (rsp_minute_out),
      .rsp_second_out   (rsp_second_out)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // ---------------------------------------------------------------- calendar model

   function automatic day_type days_in_month(month_type m, year_type y);
      case (m)
         MONTH_FEB:               return (y[1:0] == 2'd0) ? 5'd29 : 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11: return 5'd30;
         default:                 return 5'd31;
      endcase
   endfunction

   // Step a plain counter by one inside 0..top, wrapping both ways.
   function automatic int wrap_step(int v, int top, bit up);
      if (up) begin
         return (v >= top) ? 0 : v + 1;
      end
      return (v == 0) ? top : v - 1;
   endfunction

   function automatic void month_fwd();
      if (cal_now.month >= MONTH_MAX) begin
         cal_now.month = 4'd1;
         cal_now.year  = year_type'(wrap_step(int'(cal_now.year), int'(YEAR_MAX), 1'b1));
      end else begin
         cal_now.month = cal_now.month + 4'd1;
      end
   endfunction

   function automatic void month_back();
      if (cal_now.month <= 4'd1) begin
         cal_now.month = MONTH_MAX;
         cal_now.year  = year_type'(wrap_step(int'(cal_now.year), int'(YEAR_MAX), 1'b0));
      end else begin
         cal_now.month = cal_now.month - 4'd1;
      end
   endfunction

   // Take a candidate day (may be 32, so carried as int) and push an overlong one
   // to the first of the next month.
   function automatic void settle_day(int d);
      if (d > int'(days_in_month(cal_now.month, cal_now.year))) begin
         cal_now.day = 5'd1;
         month_fwd();
      end else begin
         cal_now.day = day_type'(d);
      end
   endfunction

   function automatic void step_calendar(action_type a, field_type f);
      bit up;
      up = (a == ACT_UP);
      if (a != ACT_UP && a != ACT_DOWN) begin
         return;
      end
      case (f)
         FLD_YEAR: begin
            cal_now.year = year_type'(wrap_step(int'(cal_now.year), int'(YEAR_MAX), up));
            settle_day(int'(cal_now.day));
         end
         FLD_MONTH: begin
            if (up) begin
               month_fwd();
            end else begin
               month_back();
            end
            settle_day(int'(cal_now.day));
         end
         FLD_DAY: begin
            if (up) begin
               settle_day(int'(cal_now.day) + 1);
            end else if (cal_now.day <= 5'd1) begin
               month_back();
               cal_now.day = days_in_month(cal_now.month, cal_now.year);
            end else begin
               cal_now.day = cal_now.day - 5'd1;
            end
         end
         FLD_HOUR:   cal_now.hour   = hour_type'(wrap_step(int'(cal_now.hour),
                                                           int'(HOUR_MAX), up));
         FLD_MINUTE: cal_now.minute = minute_type'(wrap_step(int'(cal_now.minute),
                                                             int'(MINUTE_MAX), up));
         FLD_SECOND: cal_now.second = second_type'(wrap_step(int'(cal_now.second),
                                                             int'(SECOND_MAX), up));
         default: ;
      endcase
   endfunction

   // ---------------------------------------------------------------- request side

   // Called at a rising edge. Hold the word until it is taken, then log what the
   // response must be. The accept is decided at the falling edge, where nothing
   // can change before the edge that takes it.
   task automatic send_word(input action_type a, input field_type f,
                            input bit use_typed, input cal_word_type typed);
      req_valid        <= 1'b1;
      req_action       <= a;
      req_field_select <= f;
      do @(negedge clock); while (req_stall);
      step_calendar(a, f);
      expected_words.push_back(use_typed ? typed : cal_now);
      @(posedge clock);
   endtask

   // Drop valid and scramble the idle payload on each idle clock (n >= 1).
   task automatic idle_cycles(input int n);
      req_valid <= 1'b0;
      repeat (n) begin
         req_action       <= action_type'($urandom_range(0, 3));
         req_field_select <= field_type'($urandom_range(0, 7));
         @(posedge clock);
      end
   endtask

   // Send in bursts of random length separated by random gaps.
   task automatic offer(input action_type a, input field_type f,
                        input bit use_typed, input cal_word_type typed);
      send_word(a, f, use_typed, typed);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         idle_cycles($urandom_range(1, 6));
         burst_left = $urandom_range(0, 24);
      end
   endtask

   // Hold off until every logged response word has come back.
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_words.size() != 0);
   endtask

   task automatic add_row(input action_type a, input field_type f, input int reps,
                          input int y, input int mo, input int d,
                          input int h, input int mi, input int s);
      step_row_type r;
      r.act   = a;
      r.fld   = f;
      r.reps  = reps;
      r.after = '{year_type'(y), month_type'(mo), day_type'(d),
                  hour_type'(h), minute_type'(mi), second_type'(s)};
      script.push_back(r);
   endtask

   // ---------------------------------------------------------------- response side

   task automatic compare_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         failures++;
      end
   endtask

   // The word on the response port is taken at the next rising edge; check it now.
   always @(negedge clock) begin : rsp_check
      cal_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_words.size() == 0) begin
            $error("response word with nothing expected");
            failures++;
         end else begin
            want = expected_words.pop_front();
            compare_field("year_out",   int'(want.year),   int'(rsp_year_out));
            compare_field("month_out",  int'(want.month),  int'(rsp_month_out));
            compare_field("day_out",    int'(want.day),    int'(rsp_day_out));
            compare_field("hour_out",   int'(want.hour),   int'(rsp_hour_out));
            compare_field("minute_out", int'(want.minute), int'(rsp_minute_out));
            compare_field("second_out", int'(want.second), int'(rsp_second_out));
         end
      end
   end

   // Stall the response side in stretches: free running, random, solid, and once
   // a long hold-off so the single response slot fills and backs up the request side.
   initial begin : rsp_pacing
      int mode;
      int span;
      wait (reset == 1'b0);
      forever begin
         if (long_hold_req && !long_hold_done) begin
            long_hold_done = 1'b1;
            repeat (LONG_HOLD) begin
               @(posedge clock);
               rsp_stall <= 1'b1;
            end
         end
         mode = $urandom_range(0, 2);
         span = (mode == 2) ? $urandom_range(1, 8) : $urandom_range(1, 30);
         repeat (span) begin
            @(posedge clock);
            case (mode)
               0:       rsp_stall <= 1'b0;
               1:       rsp_stall <= ($urandom_range(0, 2) == 0);
               default: rsp_stall <= 1'b1;
            endcase
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // ---------------------------------------------------------------- stimulus

   initial begin : stimulus
      action_type a;
      field_type  f;
      int         pick;
      int         run_len;
      int         steps_done;
      bit         mid_drained;

      cal_now = '{YEAR_RST, MONTH_RST, DAY_RST, HOUR_RST, MINUTE_RST, SECOND_RST};

      // Directed walk from reset 21-03-10 17:41:35 over the wraps and calendar corners.
      add_row(ACT_READ,   FLD_YEAR,    1, 21,  3, 10, 17, 41, 35);
      add_row(ACT_SPARE,  FLD_YEAR,    1, 21,  3, 10, 17, 41, 35);  // spare action reads
      add_row(ACT_UP,     FLD_SPARE6,  1, 21,  3, 10, 17, 41, 35);  // unused selects
      add_row(ACT_DOWN,   FLD_SPARE7,  1, 21,  3, 10, 17, 41, 35);
      add_row(ACT_UP,     FLD_HOUR,    6, 21,  3, 10, 23, 41, 35);
      add_row(ACT_UP,     FLD_HOUR,    1, 21,  3, 10,  0, 41, 35);
      add_row(ACT_DOWN,   FLD_HOUR,    1, 21,  3, 10, 23, 41, 35);
      add_row(ACT_UP,     FLD_MINUTE, 18, 21,  3, 10, 23, 59, 35);
      add_row(ACT_UP,     FLD_MINUTE,  1, 21,  3, 10, 23,  0, 35);
      add_row(ACT_DOWN,   FLD_MINUTE,  1, 21,  3, 10, 23, 59, 35);
      add_row(ACT_DOWN,   FLD_SECOND, 35, 21,  3, 10, 23, 59,  0);
      add_row(ACT_DOWN,   FLD_SECOND,  1, 21,  3, 10, 23, 59, 59);
      add_row(ACT_UP,     FLD_SECOND,  1, 21,  3, 10, 23, 59,  0);
      add_row(ACT_UP,     FLD_YEAR,   78, 99,  3, 10, 23, 59,  0);
      add_row(ACT_UP,     FLD_YEAR,    1,  0,  3, 10, 23, 59,  0);
      add_row(ACT_DOWN,   FLD_YEAR,    1, 99,  3, 10, 23, 59,  0);
      add_row(ACT_DOWN,   FLD_DAY,     9, 99,  3,  1, 23, 59,  0);
      add_row(ACT_DOWN,   FLD_DAY,     1, 99,  2, 28, 23, 59,  0);  // short February
      add_row(ACT_UP,     FLD_DAY,     1, 99,  3,  1, 23, 59,  0);
      add_row(ACT_UP,     FLD_YEAR,    1,  0,  3,  1, 23, 59,  0);
      add_row(ACT_DOWN,   FLD_DAY,     1,  0,  2, 29, 23, 59,  0);  // year 0 is leap
      add_row(ACT_DOWN,   FLD_YEAR,    1, 99,  3,  1, 23, 59,  0);  // Feb 29 lost
      add_row(ACT_DOWN,   FLD_MONTH,   2, 99,  1,  1, 23, 59,  0);
      add_row(ACT_DOWN,   FLD_DAY,     1, 98, 12, 31, 23, 59,  0);  // back over new year
      add_row(ACT_UP,     FLD_DAY,     1, 99,  1,  1, 23, 59,  0);  // forward over it
      add_row(ACT_DOWN,   FLD_DAY,     1, 98, 12, 31, 23, 59,  0);
      add_row(ACT_UP,     FLD_MONTH,   1, 99,  1, 31, 23, 59,  0);
      add_row(ACT_UP,     FLD_MONTH,   1, 99,  3,  1, 23, 59,  0);  // Jan 31 skips Feb

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Walk the table; only the last repeat of a row carries the typed-in word,
      // earlier repeats come from the model.
      foreach (script[i]) begin
         for (int k = 1; k <= script[i].reps; k++) begin
            offer(script[i].act, script[i].fld, k == script[i].reps, script[i].after);
         end
      end
      wait_drained();

      // Random runs of one action on one field, long enough now and then to wrap
      // minutes and roll days over month ends; reads and spare codes mixed in.
      long_hold_req = 1'b1;
      steps_done    = 0;
      mid_drained   = 1'b0;
      while (steps_done < STEP_TARGET) begin
         pick = $urandom_range(0, 99);
         a = (pick < 45) ? ACT_UP : (pick < 88) ? ACT_DOWN :
             (pick < 95) ? ACT_READ : ACT_SPARE;
         f = ($urandom_range(0, 19) == 0) ? field_type'($urandom_range(6, 7))
                                          : field_type'($urandom_range(0, 5));
         run_len = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 40)
                                               : $urandom_range(1, 3);
         repeat (run_len) begin
            offer(a, f, 1'b0, cal_now);
            if ((a == ACT_UP || a == ACT_DOWN) && f <= FLD_SECOND) begin
               steps_done++;
            end
         end
         if (!mid_drained && steps_done >= STEP_TARGET / 2) begin
            mid_drained = 1'b1;
            wait_drained();
         end
      end

      wait_drained();
      repeat (DRAIN_TAIL) @(posedge clock);
      if (failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
